### design/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wav stream parser
// Beat formats, parser phases, status codes and the job record that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // widest frame the block buffers
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned ITEM_W = $clog2(MAX_CHANNELS + 2);
  localparam int unsigned FB_W   = $clog2(4 * MAX_CHANNELS + 1);

  // job queue depth
  localparam int unsigned JOBQ_DEPTH = 2;

  // four-character tags, little-endian as read from the file
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FLAC = 32'h4361_4C66;

  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
  localparam logic [15:0] FMT_FLOAT      = 16'd3;
  localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
  localparam logic [31:0] EXT_MIN_SIZE   = 32'd26;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_CHAN  = 4'd6,
    PH_RATE  = 4'd7,
    PH_BRATE = 4'd8,
    PH_ALIGN = 4'd9,
    PH_BITS  = 4'd10,
    PH_EXT   = 4'd11,
    PH_SUB   = 4'd12,
    PH_SKIP  = 4'd13,
    PH_DATA  = 4'd14,
    PH_DONE  = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    TK_OTHER = 2'd0,
    TK_FMT   = 2'd1,
    TK_DATA  = 2'd2
  } tag_e;

  typedef enum logic [1:0] {
    KIND_INFO   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_COMPLETE    = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_NOT_RIFF    = 3'd2,
    ST_NOT_WAVE    = 3'd3,
    ST_NO_DATA     = 3'd4,
    ST_ZERO_FRAMES = 3'd5,
    ST_TOO_MANY    = 3'd6,
    ST_IS_FLAC     = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] sample_value;
    logic [2:0]         channel;
    logic               frame_end;
    logic [31:0]        sample_rate;
    logic [3:0]         channel_count;
    logic [5:0]         sample_bits;
    logic               is_float;
    status_e            status;
    logic               run_last;
  } out_beat_t;

  // everything one input byte causes: info, a whole frame and/or a status
  typedef struct packed {
    logic                               has_info;
    logic                               has_frame;
    logic                               has_status;
    logic [31:0]                        rate;
    logic [CNT_W-1:0]                   ccount;
    logic [5:0]                         sbits;
    logic                               flt;
    status_e                            status;
    logic [MAX_CHANNELS-1:0][31:0]      lanes;
  } job_t;

endpackage

### design/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front: byte parser
// Takes one file byte per unstalled cycle, walks the RIFF chunks, converts
// samples as their bytes arrive and pushes one job per byte that has results.
// ----------------------------------------------------------------------------
module wsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsp_pkg::in_beat_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wsp_pkg::job_t     q_job_o
);

  // last byte index of the field read in each phase
  function automatic logic [2:0] field_last(wsp_pkg::phase_e ph);
    logic [2:0] r;
    unique case (ph) inside
      wsp_pkg::PH_FMT, wsp_pkg::PH_CHAN, wsp_pkg::PH_ALIGN,
      wsp_pkg::PH_BITS, wsp_pkg::PH_SUB: r = 3'd1;
      wsp_pkg::PH_EXT:                   r = 3'd7;
      default:                           r = 3'd3;
    endcase
    return r;
  endfunction

  // ieee single to q1.31, truncating, saturating, nan and subnormal to zero
  function automatic logic [31:0] q31_from_float(logic [31:0] w);
    logic        sgn;
    logic [7:0]  e;
    logic [23:0] m;
    logic [31:0] mag;
    logic [7:0]  rsh;
    logic [31:0] res;
    sgn = w[31];
    e   = w[30:23];
    m   = {1'b0, w[22:0]};
    mag = '0;
    rsh = '0;
    res = '0;
    if (e == 8'hFF && w[22:0] != '0) begin
      res = '0;
    end else if (e >= 8'd127) begin
      res = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      if (e == 8'd0) begin
        e = 8'd1;
      end else begin
        m = {1'b1, w[22:0]};
      end
      if (e >= 8'd119) begin
        mag = {8'h00, m} << 3'(e - 8'd119);
      end else begin
        rsh = 8'd119 - e;
        mag = (rsh >= 8'd24) ? '0 : {8'h00, m >> rsh[4:0]};
      end
      res = sgn ? (32'd0 - mag) : mag;
    end
    return res;
  endfunction

  wsp_pkg::phase_e  phase_q, phase_d, phase_pre;
  logic [31:0]      fshift_q, fshift_d;
  logic [2:0]       fidx_q, fidx_d;
  logic [32:0]      left_q, left_d;
  logic [15:0]      fmt_q, fmt_d;
  logic [15:0]      ch_q, ch_d;
  logic [31:0]      rate_q, rate_d;
  logic [15:0]      bits_q, bits_d;
  logic             fvalid_q, fvalid_d;
  wsp_pkg::tag_e    tag_q, tag_d;
  logic             ext_q, ext_d;
  wsp_pkg::status_e done_q, done_d, done_pre;
  logic             flt_q, flt_d;
  logic [wsp_pkg::FB_W-1:0] fb_q, fb_d;
  logic [wsp_pkg::CH_W-1:0] chan_q, chan_d;
  logic [1:0]       sbyte_q, sbyte_d;
  logic [23:0]      asm_q, asm_d;
  logic [wsp_pkg::MAX_CHANNELS-1:0][31:0] lane_q, lane_d;
  logic             anyf_q, anyf_d, anyf_pre;

  logic        fire;
  logic        eof_fire;
  logic [7:0]  data_byte;
  logic [31:0] field_val;
  logic        field_done;
  logic [32:0] left_dec;
  logic [32:0] csize_left;
  logic [wsp_pkg::FB_W-1:0] fb_calc;
  logic        is_flt;
  logic [1:0]  slast;
  logic        sample_done;
  logic        frame_done;
  logic [31:0] sample_new;
  logic        info_push;
  logic        frame_push;

  // handshake
  assign in_stall_o = q_full_i;
  assign fire       = in_valid_i & ~q_full_i;
  assign eof_fire   = fire & in_data_i.end_of_file;
  assign data_byte  = in_data_i.data_byte;

  // field assembly and shared decodes
  assign field_val  = fidx_q[2] ? fshift_q
                    : (fshift_q | (32'(data_byte) << {fidx_q[1:0], 3'b000}));
  assign field_done = (fidx_q >= field_last(phase_q));
  assign left_dec   = (left_q != '0) ? (left_q - 33'd1) : left_q;
  assign csize_left = {1'b0, field_val} + 33'(field_val[0]);
  assign fb_calc    = wsp_pkg::FB_W'(bits_q[5:3]) *
                      wsp_pkg::FB_W'(ch_q[wsp_pkg::CNT_W-1:0]);
  assign is_flt     = (fmt_q == wsp_pkg::FMT_FLOAT) && (bits_q == 16'd32);
  assign slast      = 2'(bits_q[5:3] - 3'd1);
  assign sample_done = (sbyte_q == slast);
  assign frame_done = (wsp_pkg::CNT_W'(chan_q) ==
                       (ch_q[wsp_pkg::CNT_W-1:0] - wsp_pkg::CNT_W'(1)));

  // sample made whole by this byte, left-justified
  always_comb begin
    case (bits_q[5:3])
      3'd1:    sample_new = {data_byte ^ 8'h80, 24'h000000};
      3'd2:    sample_new = {data_byte, asm_q[7:0], 16'h0000};
      3'd3:    sample_new = {data_byte, asm_q[15:0], 8'h00};
      default: sample_new = flt_q ? q31_from_float({data_byte, asm_q})
                                  : {data_byte, asm_q};
    endcase
  end

  // next state of the parser
  always_comb begin
    phase_d  = phase_q;
    fshift_d = fshift_q;
    fidx_d   = fidx_q;
    left_d   = left_q;
    fmt_d    = fmt_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    fvalid_d = fvalid_q;
    tag_d    = tag_q;
    ext_d    = ext_q;
    done_d   = done_q;
    flt_d    = flt_q;
    fb_d     = fb_q;
    chan_d   = chan_q;
    sbyte_d  = sbyte_q;
    asm_d    = asm_q;
    lane_d   = lane_q;
    anyf_d   = anyf_q;
    if (fire) begin
      unique case (phase_q)
        wsp_pkg::PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) phase_d = wsp_pkg::PH_CID;
        end
        wsp_pkg::PH_DATA: begin
          left_d = left_dec;
          if (sample_done) begin
            sbyte_d        = '0;
            lane_d[chan_q] = sample_new;
            if (frame_done) begin
              anyf_d = 1'b1;
              chan_d = '0;
              if (left_dec < 33'(fb_q)) begin
                phase_d = wsp_pkg::PH_DONE;
                done_d  = wsp_pkg::ST_COMPLETE;
              end
            end else begin
              chan_d = chan_q + wsp_pkg::CH_W'(1);
            end
          end else begin
            case (sbyte_q)
              2'd0:    asm_d[7:0]   = data_byte;
              2'd1:    asm_d[15:8]  = data_byte;
              default: asm_d[23:16] = data_byte;
            endcase
            sbyte_d = sbyte_q + 2'd1;
          end
        end
        wsp_pkg::PH_DONE: begin
          phase_d = phase_q;
        end
        default: begin
          if (phase_q >= wsp_pkg::PH_FMT) left_d = left_dec;
          fshift_d = field_val;
          if (!field_done) begin
            fidx_d = fidx_q + 3'd1;
          end else begin
            fshift_d = '0;
            fidx_d   = '0;
            unique case (phase_q)
              wsp_pkg::PH_RIFF: begin
                if (field_val == wsp_pkg::TAG_FLAC) begin
                  phase_d = wsp_pkg::PH_DONE;
                  done_d  = wsp_pkg::ST_IS_FLAC;
                end else if (field_val != wsp_pkg::TAG_RIFF) begin
                  phase_d = wsp_pkg::PH_DONE;
                  done_d  = wsp_pkg::ST_NOT_RIFF;
                end else begin
                  phase_d = wsp_pkg::PH_RSIZE;
                end
              end
              wsp_pkg::PH_RSIZE: phase_d = wsp_pkg::PH_WAVE;
              wsp_pkg::PH_WAVE: begin
                if (field_val != wsp_pkg::TAG_WAVE) begin
                  phase_d = wsp_pkg::PH_DONE;
                  done_d  = wsp_pkg::ST_NOT_WAVE;
                end else begin
                  phase_d = wsp_pkg::PH_CID;
                end
              end
              wsp_pkg::PH_CID: begin
                if (field_val == wsp_pkg::TAG_FMT)       tag_d = wsp_pkg::TK_FMT;
                else if (field_val == wsp_pkg::TAG_DATA) tag_d = wsp_pkg::TK_DATA;
                else                                     tag_d = wsp_pkg::TK_OTHER;
                phase_d = wsp_pkg::PH_CSIZE;
              end
              wsp_pkg::PH_CSIZE: begin
                left_d = csize_left;
                if (tag_q == wsp_pkg::TK_FMT) begin
                  fvalid_d = 1'b0;
                  ext_d    = (field_val >= wsp_pkg::EXT_MIN_SIZE);
                  if (field_val >= wsp_pkg::FMT_MIN_SIZE) phase_d = wsp_pkg::PH_FMT;
                  else phase_d = (csize_left != '0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
                end else if (tag_q == wsp_pkg::TK_DATA && fvalid_q) begin
                  if (ch_q > 16'(wsp_pkg::MAX_CHANNELS)) begin
                    phase_d = wsp_pkg::PH_DONE;
                    done_d  = wsp_pkg::ST_TOO_MANY;
                  end else begin
                    left_d  = {1'b0, field_val};
                    chan_d  = '0;
                    sbyte_d = '0;
                    fb_d    = fb_calc;
                    flt_d   = is_flt;
                    if ({1'b0, field_val} < 33'(fb_calc)) begin
                      phase_d = wsp_pkg::PH_DONE;
                      done_d  = wsp_pkg::ST_ZERO_FRAMES;
                    end else begin
                      phase_d = wsp_pkg::PH_DATA;
                    end
                  end
                end else begin
                  phase_d = (csize_left != '0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
                end
              end
              wsp_pkg::PH_FMT: begin
                fmt_d   = field_val[15:0];
                phase_d = wsp_pkg::PH_CHAN;
              end
              wsp_pkg::PH_CHAN: begin
                ch_d    = field_val[15:0];
                phase_d = wsp_pkg::PH_RATE;
              end
              wsp_pkg::PH_RATE: begin
                rate_d  = field_val;
                phase_d = wsp_pkg::PH_BRATE;
              end
              wsp_pkg::PH_BRATE: phase_d = wsp_pkg::PH_ALIGN;
              wsp_pkg::PH_ALIGN: phase_d = wsp_pkg::PH_BITS;
              wsp_pkg::PH_BITS: begin
                bits_d   = field_val[15:0];
                fvalid_d = (ch_q != '0) && (rate_q != '0) &&
                           (field_val[15:0] == 16'd8  || field_val[15:0] == 16'd16 ||
                            field_val[15:0] == 16'd24 || field_val[15:0] == 16'd32);
                if (fmt_q == wsp_pkg::FMT_EXTENSIBLE && ext_q) phase_d = wsp_pkg::PH_EXT;
                else phase_d = (left_dec != '0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
              end
              wsp_pkg::PH_EXT: phase_d = wsp_pkg::PH_SUB;
              wsp_pkg::PH_SUB: begin
                fmt_d   = field_val[15:0];
                phase_d = (left_dec != '0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
              end
              default: phase_d = phase_q;
            endcase
          end
        end
      endcase
    end

    phase_pre = phase_d;
    done_pre  = done_d;
    anyf_pre  = anyf_d;

    // the final byte rearms the parser
    if (eof_fire) begin
      phase_d  = wsp_pkg::PH_RIFF;
      fshift_d = '0;
      fidx_d   = '0;
      left_d   = '0;
      fmt_d    = '0;
      ch_d     = '0;
      rate_d   = '0;
      bits_d   = '0;
      fvalid_d = 1'b0;
      tag_d    = wsp_pkg::TK_OTHER;
      ext_d    = 1'b0;
      done_d   = wsp_pkg::ST_COMPLETE;
      flt_d    = 1'b0;
      fb_d     = '0;
      chan_d   = '0;
      sbyte_d  = '0;
      anyf_d   = 1'b0;
    end
  end

  // job decodes
  assign info_push  = fire && (phase_q == wsp_pkg::PH_CSIZE) && field_done &&
                      (tag_q == wsp_pkg::TK_DATA) && fvalid_q &&
                      (ch_q <= 16'(wsp_pkg::MAX_CHANNELS));
  assign frame_push = fire && (phase_q == wsp_pkg::PH_DATA) && sample_done && frame_done;

  // job toward the back part
  always_comb begin
    q_job_o            = '0;
    q_job_o.has_info   = info_push;
    q_job_o.has_frame  = frame_push;
    q_job_o.has_status = eof_fire;
    q_job_o.rate       = rate_q;
    q_job_o.ccount     = ch_q[wsp_pkg::CNT_W-1:0];
    q_job_o.sbits      = bits_q[5:0];
    q_job_o.flt        = is_flt;
    q_job_o.lanes      = lane_d;
    unique case (phase_pre) inside
      wsp_pkg::PH_RIFF:                   q_job_o.status = wsp_pkg::ST_NOT_RIFF;
      wsp_pkg::PH_RSIZE, wsp_pkg::PH_WAVE: q_job_o.status = wsp_pkg::ST_NOT_WAVE;
      wsp_pkg::PH_DATA: q_job_o.status = anyf_pre ? wsp_pkg::ST_TRUNCATED
                                                  : wsp_pkg::ST_ZERO_FRAMES;
      wsp_pkg::PH_DONE:                   q_job_o.status = done_pre;
      default:                            q_job_o.status = wsp_pkg::ST_NO_DATA;
    endcase
  end

  assign q_push_o = info_push | frame_push | eof_fire;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsp_pkg::PH_RIFF;
      fshift_q <= '0;
      fidx_q   <= '0;
      left_q   <= '0;
      fmt_q    <= '0;
      ch_q     <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      fvalid_q <= 1'b0;
      tag_q    <= wsp_pkg::TK_OTHER;
      ext_q    <= 1'b0;
      done_q   <= wsp_pkg::ST_COMPLETE;
      flt_q    <= 1'b0;
      fb_q     <= '0;
      chan_q   <= '0;
      sbyte_q  <= '0;
      anyf_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fshift_q <= fshift_d;
      fidx_q   <= fidx_d;
      left_q   <= left_d;
      fmt_q    <= fmt_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      fvalid_q <= fvalid_d;
      tag_q    <= tag_d;
      ext_q    <= ext_d;
      done_q   <= done_d;
      flt_q    <= flt_d;
      fb_q     <= fb_d;
      chan_q   <= chan_d;
      sbyte_q  <= sbyte_d;
      anyf_q   <= anyf_d;
    end
  end

  // sample payload
  always_ff @(posedge clk_i) begin
    asm_q  <= asm_d;
    lane_q <= lane_d;
  end

endmodule

### design/wsp_jobq.sv
// ----------------------------------------------------------------------------
// wsp_jobq: short job queue
// Decouples the byte parser from the result emitter.
// ----------------------------------------------------------------------------
module wsp_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsp_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output wsp_pkg::job_t head_o
);

  localparam int unsigned PTR_W = (wsp_pkg::JOBQ_DEPTH > 1) ?
                                  $clog2(wsp_pkg::JOBQ_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(wsp_pkg::JOBQ_DEPTH + 1);

  wsp_pkg::job_t     mem_q [wsp_pkg::JOBQ_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(wsp_pkg::JOBQ_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_q];

  // pointers and fill level
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(wsp_pkg::JOBQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(wsp_pkg::JOBQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + QCNT_W'(1);
    else if (pop_i && !push_i) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

### design/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back: result emitter
// Walks the head job, one result per unstalled cycle, to a registered output.
// ----------------------------------------------------------------------------
module wsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  wsp_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wsp_pkg::out_beat_t out_data_o
);

  logic [wsp_pkg::ITEM_W-1:0] cnt_q, cnt_d;
  logic [wsp_pkg::ITEM_W-1:0] total;
  logic [wsp_pkg::ITEM_W-1:0] idx;
  logic                       is_last;
  logic                       load;
  logic                       out_valid_q, out_valid_d;
  wsp_pkg::out_beat_t         out_q, item;

  // results in the head job
  assign total = wsp_pkg::ITEM_W'(head_i.has_info) +
                 (head_i.has_frame ? wsp_pkg::ITEM_W'(head_i.ccount) : '0) +
                 wsp_pkg::ITEM_W'(head_i.has_status);
  assign idx     = cnt_q - wsp_pkg::ITEM_W'(head_i.has_info);
  assign is_last = (cnt_q == total - wsp_pkg::ITEM_W'(1));
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  // pick the current result
  always_comb begin
    item = '0;
    if (head_i.has_info && cnt_q == '0) begin
      item.kind          = wsp_pkg::KIND_INFO;
      item.sample_rate   = head_i.rate;
      item.channel_count = 4'(head_i.ccount);
      item.sample_bits   = head_i.sbits;
      item.is_float      = head_i.flt;
    end else if (head_i.has_frame && idx < wsp_pkg::ITEM_W'(head_i.ccount)) begin
      item.kind         = wsp_pkg::KIND_SAMPLE;
      item.sample_value = head_i.lanes[idx[wsp_pkg::CH_W-1:0]];
      item.channel      = 3'(idx);
      item.frame_end    = (idx == wsp_pkg::ITEM_W'(head_i.ccount) - wsp_pkg::ITEM_W'(1));
    end else begin
      item.kind   = wsp_pkg::KIND_STATUS;
      item.status = head_i.status;
    end
    item.run_last = is_last;
  end

  // step counter and output beat valid
  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      cnt_d       = is_last ? '0 : cnt_q + wsp_pkg::ITEM_W'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= item;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/wav_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_stream_parser_unit: RIFF/WAVE PCM stream parser
// Parses a file one byte per beat and emits format info, Q1.31 samples and a
// final status per file.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                | beat
//   in       | input     | in_valid_i / in_stall_o  | in_beat_t: one file byte, eof
//   out      | output    | out_valid_o / out_stall_i| out_beat_t: one result
//
// One byte is taken each cycle while in_stall_o is low; the parser decides
// its results in that cycle. Results leave one per cycle from the emitter
// while unstalled: n for a frame of n channels (n+1 with the final status).
// The two-entry job queue sets when input stalls: in_stall_o rises only while
// it is full. Reset is asynchronous and puts the parser at the RIFF tag.
// ----------------------------------------------------------------------------
module wav_stream_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wsp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wsp_pkg::out_beat_t out_data_o
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_head_valid;
  wsp_pkg::job_t q_job;
  wsp_pkg::job_t q_head;

  // byte parser
  wsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  // job queue
  wsp_jobq u_jobq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .job_i        (q_job),
    .pop_i        (q_pop),
    .full_o       (q_full),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  // result emitter
  wsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### design/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker: port-level checks for the wav stream parser
// Watches the output beats of the top level.
// ----------------------------------------------------------------------------
module wsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input wsp_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wsp_pkg::out_beat_t out_data_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // a status always closes the byte's results
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == wsp_pkg::KIND_STATUS |-> out_data_o.run_last)
    else $error("status beat without run_last");

  // nothing closes a byte in the middle of a frame
  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == wsp_pkg::KIND_SAMPLE && !out_data_o.frame_end
    |-> !out_data_o.run_last)
    else $error("run_last inside a frame");

  // sample fields are clear on other beats
  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != wsp_pkg::KIND_SAMPLE
    |-> out_data_o.sample_value == '0 && out_data_o.channel == '0 && !out_data_o.frame_end)
    else $error("sample fields set on a non-sample beat");

endmodule

bind wav_stream_parser_unit wsp_checker u_wsp_checker (.*);
